// ===== rtl/pps_pkg.sv =====
// Shared types and constants for the prime sieve block.
package pps_pkg;

  // Candidate width and the bit counter of the remainder unit
  localparam int CAND_W   = 31;
  localparam int BIT_CNT_W = 5;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_LOAD,
    ST_DIV,
    ST_CHECK,
    ST_EMIT,
    ST_FINISH
  } pps_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;   // capture the input transfer
    logic rd_en;     // read stored prime at the current stage index
    logic load_div;  // start a remainder run with the read prime
    logic div_step;  // one restoring remainder step
    logic next_k;    // move on to the next stage
    logic emit;      // load the output register, store the prime if room
    logic finish;    // item done, clear stages if end of run
  } pps_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cand_small;  // candidate below two
    logic k_at_fill;   // all filled stages tested
    logic bit_last;    // last remainder step in progress
    logic rem_zero;    // remainder is zero, candidate dropped
    logic out_free;    // output register can take a result
  } pps_status_t;

endpackage

// ===== rtl/pps_ram.sv =====
// Generic single-port RAM with registered read.
module pps_ram #(
  parameter int WIDTH  = 31,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pps_ctrl.sv =====
// Controller state machine of the prime sieve.
module pps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pps_pkg::pps_status_t status_i,
  output pps_pkg::pps_cmd_t    cmd_o
);
  import pps_pkg::*;

  pps_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (status_i.cand_small) begin
          state_d = ST_FINISH;
        end else if (status_i.k_at_fill) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load_div = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.bit_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.rem_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.next_k = 1'b1;
          state_d      = ST_NEXT;
        end
      end
      ST_EMIT: begin
        // wait for the output register to drain
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pps_dp.sv =====
// Datapath of the prime sieve: item registers, prime store, remainder unit, output register.
module pps_dp #(
  parameter int STAGES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pps_pkg::pps_cmd_t            cmd_i,
  output pps_pkg::pps_status_t         status_o,
  input  logic [pps_pkg::CAND_W-1:0]   candidate_i,
  input  logic                         end_of_run_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pps_pkg::CAND_W-1:0]   prime_found_o,
  output logic                         uncertain_o
);
  import pps_pkg::*;

  localparam int AW = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int CW = $clog2(STAGES + 1);

  logic [CAND_W-1:0]    cand_q;
  logic                 last_q;
  logic [CW-1:0]        k_q, k_d;
  logic [CW-1:0]        filled_q, filled_d;
  logic [CAND_W-1:0]    div_q;
  logic [CAND_W-1:0]    rem_q, rem_d;
  logic [BIT_CNT_W-1:0] bit_q, bit_d;
  logic                 out_valid_q, out_valid_d;
  logic [CAND_W-1:0]    out_prime_q;
  logic                 out_unc_q;

  logic              full;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [CAND_W-1:0] ram_rdata;
  logic [CAND_W:0]   rem_shift;
  logic [CAND_W:0]   rem_sub;

  assign full = (filled_q == CW'(STAGES));

  // Prime store, written at the fill point, read at the stage under test
  assign ram_we   = cmd_i.emit && !full;
  assign ram_addr = cmd_i.emit ? filled_q[AW-1:0] : k_q[AW-1:0];

  pps_ram #(
    .WIDTH (CAND_W),
    .DEPTH (STAGES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.rd_en),
    .addr_i  (ram_addr),
    .wdata_i (cand_q),
    .rdata_o (ram_rdata)
  );

  // Restoring remainder step, MSB first
  assign rem_shift = {rem_q, cand_q[bit_q]};
  assign rem_sub   = rem_shift - {1'b0, div_q};

  always_comb begin
    rem_d = rem_q;
    bit_d = bit_q;
    if (cmd_i.load_div) begin
      rem_d = '0;
      bit_d = BIT_CNT_W'(CAND_W - 1);
    end else if (cmd_i.div_step) begin
      rem_d = (rem_shift >= {1'b0, div_q}) ? rem_sub[CAND_W-1:0] : rem_shift[CAND_W-1:0];
      bit_d = bit_q - BIT_CNT_W'(1);
    end
  end

  // Stage index and fill count
  always_comb begin
    k_d      = k_q;
    filled_d = filled_q;
    if (cmd_i.load_in) begin
      k_d = '0;
    end else if (cmd_i.next_k) begin
      k_d = k_q + CW'(1);
    end
    if (ram_we) begin
      filled_d = filled_q + CW'(1);
    end
    if (cmd_i.finish && last_q) begin
      filled_d = '0;
    end
  end

  // Output valid: set on emit, cleared by the output transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      filled_q    <= filled_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cand_q <= candidate_i;
      last_q <= end_of_run_i;
    end
    if (cmd_i.load_div) begin
      div_q <= ram_rdata;
    end
    rem_q <= rem_d;
    bit_q <= bit_d;
    if (cmd_i.emit) begin
      out_prime_q <= cand_q;
      out_unc_q   <= full;
    end
  end

  assign status_o.cand_small = (cand_q < CAND_W'(2));
  assign status_o.k_at_fill  = (k_q == filled_q);
  assign status_o.bit_last   = (bit_q == '0);
  assign status_o.rem_zero   = (rem_q == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign prime_found_o = out_prime_q;
  assign uncertain_o   = out_unc_q;

endmodule

// ===== rtl/pipelined_prime_sieve_top.sv =====
// Top level of the prime sieve: controller and datapath.
//
// Each candidate is tested against the stored primes one stage at a time with a
// single shared bit-serial remainder unit; the primes sit in a single-port RAM of
// STAGES entries. For each prime tested, the stored prime is read, loaded into the
// remainder unit and run through 31 remainder steps, and the remainder is checked;
// this goes on until the candidate is dropped or all filled stages are passed. A
// result is then emitted once the output register is free. A candidate below two
// finishes without any remainder run. One item is in work at a time; a new item
// is taken while the previous result still waits at the output. The fill count
// tracks which stages hold primes, so no clearing pass is needed after reset or
// after an end-of-run mark.
module pipelined_prime_sieve_top #(
  parameter int STAGES = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pps_pkg::CAND_W-1:0] candidate_i,
  input  logic                       end_of_run_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pps_pkg::CAND_W-1:0] prime_found_o,
  output logic                       uncertain_o
);
  import pps_pkg::*;

  pps_cmd_t    cmd;
  pps_status_t status;

  pps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pps_dp #(
    .STAGES (STAGES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .candidate_i   (candidate_i),
    .end_of_run_i  (end_of_run_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .prime_found_o (prime_found_o),
    .uncertain_o   (uncertain_o)
  );

endmodule
